// ----- hdl/bpf_pkg.sv -----
// bpf_pkg: shared constants, types and rounding helpers for the bezier path follower
// no dependencies
package bpf_pkg;

    localparam int CW  = 21;
    localparam int CF  = 10;
    localparam int PF  = 16;
    localparam int PW  = 18;
    localparam int MW  = 24;
    localparam int PRW = 48;
    localparam int PTW = 63;
    localparam int SPW = 16;
    localparam int DTW = 16;
    localparam int IRW = 24;

    localparam logic signed [PW-1:0] PARAM_ONE   = PW'(1 << PF);
    localparam logic signed [PW-1:0] PARAM_STEP  = PW'(((1 << PF) * 2 + 50) / 100);
    localparam logic signed [PW-1:0] PARAM_START = PW'(((1 << PF) + 5) / 10);
    localparam logic [SPW-1:0]       SPEED_RESET = SPW'(2048);

    localparam logic [2:0] REG_POINT_ZERO  = 3'd0;
    localparam logic [2:0] REG_POINT_ONE   = 3'd1;
    localparam logic [2:0] REG_POINT_TWO   = 3'd2;
    localparam logic [2:0] REG_POINT_THREE = 3'd3;
    localparam logic [2:0] REG_MOVE_SPEED  = 3'd4;

    typedef logic signed [CW-1:0]  coord_t;
    typedef logic signed [CW:0]    diff_t;
    typedef logic signed [MW-1:0]  op_t;
    typedef logic signed [PRW-1:0] wide_t;
    typedef logic [PTW-1:0]        point_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } iter_ctl_t;

    function automatic wide_t rnd_shr(wide_t v, int unsigned s);
        wide_t mag;
        wide_t r;
        mag = v[PRW-1] ? -v : v;
        r = (mag + (wide_t'(1) <<< (s - 1))) >>> s;
        return v[PRW-1] ? -r : r;
    endfunction

    function automatic coord_t sat_coord(wide_t v);
        wide_t hi;
        wide_t lo;
        hi = wide_t'((1 << (CW - 1)) - 1);
        lo = -wide_t'(1 << (CW - 1));
        if (v > hi)
            return coord_t'(hi);
        if (v < lo)
            return coord_t'(lo);
        return coord_t'(v);
    endfunction

    function automatic coord_t coord_of(point_t p, logic [1:0] axis);
        return coord_t'(p[int'(axis) * CW +: CW]);
    endfunction

endpackage

// ----- hdl/bpf_if.sv -----
// bpf_if: valid/ready channels for tick items and position results
// depends on bpf_pkg
interface bpf_tick_if;
    logic                  valid;
    logic                  ready;
    logic [bpf_pkg::DTW-1:0] time_step;
    modport source (output valid, output time_step, input ready);
    modport sink (input valid, input time_step, output ready);
endinterface

interface bpf_pos_if;
    logic                   valid;
    logic                   ready;
    logic [bpf_pkg::CW-1:0] pos_x;
    logic [bpf_pkg::CW-1:0] pos_y;
    logic [bpf_pkg::CW-1:0] pos_z;
    logic                   target_reached;
    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output target_reached, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
                  input target_reached, output ready);
endinterface

// ----- hdl/bpf_mul.sv -----
// bpf_mul: shared signed multiplier with registered product
// depends on bpf_pkg
module bpf_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  bpf_pkg::op_t    a,
    input  bpf_pkg::op_t    b,
    output bpf_pkg::wide_t  prod
);
    import bpf_pkg::*;

    wide_t prod_reg;
    wide_t prod_next;

    assign prod_next = wide_t'(a) * wide_t'(b);
    assign prod = prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_reg <= '0;
        else
            prod_reg <= prod_next;
    end
endmodule

// ----- hdl/bpf_iter.sv -----
// bpf_iter: one-bit-per-cycle integer square root and restoring divider
// depends on bpf_pkg
module bpf_iter (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bpf_pkg::iter_ctl_t      ctl,
    input  logic [bpf_pkg::PRW-1:0] num,
    input  logic [bpf_pkg::IRW-1:0] den,
    output logic                    done,
    output logic [bpf_pkg::IRW-1:0] res
);
    import bpf_pkg::*;

    localparam int SQRT_STEPS = 23;
    localparam int DIV_STEPS  = 42;

    logic           busy_reg, busy_next;
    logic           div_reg, div_next;
    logic           done_reg, done_next;
    logic [5:0]     cnt_reg, cnt_next;
    logic [PRW-1:0] a_reg, a_next;
    logic [PRW-1:0] b_reg, b_next;
    logic [PRW-1:0] bit_reg, bit_next;
    logic [IRW-1:0] q_reg, q_next;
    logic [IRW-1:0] den_reg, den_next;
    logic [PRW-1:0] trial;
    logic [PRW-1:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        bit_next  = bit_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        trial     = b_reg + bit_reg;
        rem_sh    = {b_reg[PRW-2:0], a_reg[DIV_STEPS-1]};
        if (ctl.start)
        begin
            busy_next = 1'b1;
            div_next  = ctl.is_div;
            a_next    = num;
            b_next    = '0;
            bit_next  = PRW'(1) << 44;
            q_next    = '0;
            den_next  = den;
            cnt_next  = ctl.is_div ? 6'(DIV_STEPS) : 6'(SQRT_STEPS);
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (rem_sh >= PRW'(den_reg))
                begin
                    b_next = rem_sh - PRW'(den_reg);
                    q_next = {q_reg[IRW-2:0], 1'b1};
                end
                else
                begin
                    b_next = rem_sh;
                    q_next = {q_reg[IRW-2:0], 1'b0};
                end
                a_next = a_reg << 1;
            end
            else
            begin
                if (a_reg >= trial)
                begin
                    a_next = a_reg - trial;
                    b_next = (b_reg >> 1) + bit_reg;
                end
                else
                    b_next = b_reg >> 1;
                bit_next = bit_reg >> 2;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign res  = div_reg ? q_reg : b_reg[IRW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            div_reg  <= div_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        bit_reg <= bit_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end
endmodule

// ----- hdl/bezier_path_follower_unit.sv -----
// bezier_path_follower_unit: top level, sequencer around a shared multiplier and
// a shared root/divide unit; depends on bpf_pkg, bpf_if, bpf_mul, bpf_iter
//
// One tick item yields one position result. The sequencer runs the main products
// through one 24x24 multiplier and one iterative unit that makes one bit per cycle.
// A tick evaluates a new target on the curve only when the last target was reached.
// A tick that reaches S_OUT while the previous result still waits for ready stays
// there until that result is taken. The three 42-step divisions of the velocity
// take most of the time per tick, the 23-step square root most of the rest. Ticks
// are taken one at a time.
module bezier_path_follower_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [62:0]         cfg_data,
    bpf_tick_if.sink            tick,
    bpf_pos_if.source           result
);
    import bpf_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_START  = 5'd1;
    localparam logic [4:0] S_T2     = 5'd2;
    localparam logic [4:0] S_U2     = 5'd3;
    localparam logic [4:0] S_W3     = 5'd4;
    localparam logic [4:0] S_W0     = 5'd5;
    localparam logic [4:0] S_W1     = 5'd6;
    localparam logic [4:0] S_W2     = 5'd7;
    localparam logic [4:0] S_ACC    = 5'd8;
    localparam logic [4:0] S_STEP   = 5'd9;
    localparam logic [4:0] S_SQ0    = 5'd10;
    localparam logic [4:0] S_SQ1    = 5'd11;
    localparam logic [4:0] S_SQ2    = 5'd12;
    localparam logic [4:0] S_SQ3    = 5'd13;
    localparam logic [4:0] S_SQRT   = 5'd14;
    localparam logic [4:0] S_VMUL   = 5'd15;
    localparam logic [4:0] S_VDIV   = 5'd16;
    localparam logic [4:0] S_VWAIT  = 5'd17;
    localparam logic [4:0] S_REACH0 = 5'd18;
    localparam logic [4:0] S_REACH1 = 5'd19;
    localparam logic [4:0] S_REACH2 = 5'd20;
    localparam logic [4:0] S_OUT    = 5'd21;

    logic [4:0]     state_reg, state_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic [1:0]     axis_reg, axis_next;
    logic [DTW-1:0] dt_reg, dt_next;
    logic signed [PW-1:0] t_reg, t_next;
    logic           fwd_reg, fwd_next;
    logic           reached_reg, reached_next;
    logic           started_reg, started_next;
    logic           neg_reg, neg_next;
    coord_t         tgt_reg[3], tgt_next[3];
    coord_t         cur_reg[3], cur_next[3];
    diff_t          d_reg[3], d_next[3];
    op_t            w_reg[4], w_next[4];
    op_t            t2_reg, t2_next;
    op_t            u2_reg, u2_next;
    op_t            step_reg, step_next;
    wide_t          acc_reg, acc_next;
    wide_t          sq_reg, sq_next;
    wide_t          r_reg, r_next;
    logic [IRW-1:0] len_reg, len_next;
    point_t         pt_reg[4];
    logic [SPW-1:0] speed_reg;
    logic           ovalid_reg, ovalid_next;
    coord_t         ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic           orch_reg, orch_next;

    op_t            mul_a, mul_b;
    wide_t          prod;
    iter_ctl_t      ictl;
    logic [PRW-1:0] inum;
    logic [IRW-1:0] iden;
    logic           idone;
    logic [IRW-1:0] ires;

    op_t            u_val;
    logic [3:0]     prev_cnt;
    wide_t          sum;
    wide_t          mag;
    wide_t          vel;
    wide_t          dx, dz;
    logic signed [PW-1:0] t_step;

    bpf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod)
    );

    bpf_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ictl),
        .num   (inum),
        .den   (iden),
        .done  (idone),
        .res   (ires)
    );

    assign tick.ready            = (state_reg == S_IDLE);
    assign result.valid          = ovalid_reg;
    assign result.pos_x          = ox_reg;
    assign result.pos_y          = oy_reg;
    assign result.pos_z          = oz_reg;
    assign result.target_reached = orch_reg;

    assign u_val    = op_t'(PARAM_ONE) - op_t'(t_reg);
    assign prev_cnt = cnt_reg - 4'd1;
    assign sum      = acc_reg + prod;
    assign mag      = prod[PRW-1] ? -prod : prod;
    assign vel      = neg_reg ? -wide_t'(ires) : wide_t'(ires);
    assign dx       = wide_t'(tgt_reg[0]) - wide_t'(cur_reg[0]);
    assign dz       = wide_t'(tgt_reg[2]) - wide_t'(cur_reg[2]);
    assign t_step   = fwd_reg ? t_reg + PARAM_STEP : t_reg - PARAM_STEP;

    // multiplier operands per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_T2:
            begin
                mul_a = op_t'(t_reg);
                mul_b = op_t'(t_reg);
            end
            S_U2:
            begin
                mul_a = u_val;
                mul_b = u_val;
            end
            S_W3:
            begin
                mul_a = t2_next;
                mul_b = op_t'(t_reg);
            end
            S_W0:
            begin
                mul_a = u2_next;
                mul_b = u_val;
            end
            S_W1:
            begin
                mul_a = op_t'(t_reg) * op_t'(3);
                mul_b = u2_reg;
            end
            S_W2:
            begin
                mul_a = t2_reg * op_t'(3);
                mul_b = u_val;
            end
            S_ACC:
            begin
                mul_a = w_next[cnt_reg[1:0]];
                mul_b = op_t'(coord_of(pt_reg[cnt_reg[1:0]], cnt_reg[3:2]));
            end
            S_STEP:
            begin
                mul_a = op_t'(speed_reg);
                mul_b = op_t'(dt_reg);
            end
            S_SQ0:
            begin
                mul_a = op_t'(d_reg[0]);
                mul_b = op_t'(d_reg[0]);
            end
            S_SQ1:
            begin
                mul_a = op_t'(d_reg[1]);
                mul_b = op_t'(d_reg[1]);
            end
            S_SQ2:
            begin
                mul_a = op_t'(d_reg[2]);
                mul_b = op_t'(d_reg[2]);
            end
            S_VMUL:
            begin
                mul_a = op_t'(d_reg[axis_reg]);
                mul_b = step_reg;
            end
            S_REACH0:
            begin
                mul_a = op_t'(dx);
                mul_b = op_t'(dx);
            end
            S_REACH1:
            begin
                mul_a = op_t'(dz);
                mul_b = op_t'(dz);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        axis_next    = axis_reg;
        dt_next      = dt_reg;
        t_next       = t_reg;
        fwd_next     = fwd_reg;
        reached_next = reached_reg;
        started_next = started_reg;
        neg_next     = neg_reg;
        tgt_next     = tgt_reg;
        cur_next     = cur_reg;
        d_next       = d_reg;
        w_next       = w_reg;
        t2_next      = t2_reg;
        u2_next      = u2_reg;
        step_next    = step_reg;
        acc_next     = acc_reg;
        sq_next      = sq_reg;
        r_next       = r_reg;
        len_next     = len_reg;
        ovalid_next  = ovalid_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        oz_next      = oz_reg;
        orch_next    = orch_reg;
        ictl         = '0;
        inum         = '0;
        iden         = '0;

        if (result.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (tick.valid)
                begin
                    dt_next    = tick.time_step;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!started_reg)
                begin
                    for (int i = 0; i < 3; i++)
                        cur_next[i] = coord_of(pt_reg[0], 2'(i));
                    started_next = 1'b1;
                end
                state_next = reached_reg ? S_T2 : S_STEP;
            end
            S_T2:
                state_next = S_U2;
            S_U2:
            begin
                t2_next    = op_t'(rnd_shr(prod, PF));
                state_next = S_W3;
            end
            S_W3:
            begin
                u2_next    = op_t'(rnd_shr(prod, PF));
                state_next = S_W0;
            end
            S_W0:
            begin
                w_next[3]  = op_t'(rnd_shr(prod, PF));
                state_next = S_W1;
            end
            S_W1:
            begin
                w_next[0]  = op_t'(rnd_shr(prod, PF));
                state_next = S_W2;
            end
            S_W2:
            begin
                w_next[1]  = op_t'(rnd_shr(prod, PF));
                cnt_next   = '0;
                acc_next   = '0;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (cnt_reg == 4'd0)
                    w_next[2] = op_t'(rnd_shr(prod, PF));
                else if (prev_cnt[1:0] == 2'd3)
                begin
                    tgt_next[prev_cnt[3:2]] = sat_coord(rnd_shr(sum, PF));
                    acc_next = '0;
                end
                else
                    acc_next = sum;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd12)
                begin
                    t_next = t_step;
                    if (t_step < 0)
                        fwd_next = 1'b1;
                    if (t_step > PARAM_ONE)
                        fwd_next = 1'b0;
                    reached_next = 1'b0;
                    state_next   = S_STEP;
                end
            end
            S_STEP:
            begin
                for (int i = 0; i < 3; i++)
                    d_next[i] = diff_t'(tgt_reg[i]) - diff_t'(cur_reg[i]);
                state_next = S_SQ0;
            end
            S_SQ0:
            begin
                step_next  = op_t'((prod + wide_t'(1 << (23 - CF))) >>> (24 - CF));
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                sq_next    = prod;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                sq_next    = sq_reg + prod;
                state_next = S_SQ3;
            end
            S_SQ3:
            begin
                ictl.start  = 1'b1;
                ictl.is_div = 1'b0;
                inum        = PRW'(sq_reg + prod);
                state_next  = S_SQRT;
            end
            S_SQRT:
            begin
                if (idone)
                begin
                    len_next   = ires;
                    axis_next  = '0;
                    state_next = (ires == '0) ? S_REACH0 : S_VMUL;
                end
            end
            S_VMUL:
                state_next = S_VDIV;
            S_VDIV:
            begin
                neg_next    = prod[PRW-1];
                ictl.start  = 1'b1;
                ictl.is_div = 1'b1;
                inum        = PRW'((mag <<< 1) + wide_t'(len_reg));
                iden        = len_reg << 1;
                state_next  = S_VWAIT;
            end
            S_VWAIT:
            begin
                if (idone)
                begin
                    cur_next[axis_reg] = sat_coord(wide_t'(cur_reg[axis_reg]) + vel);
                    axis_next = axis_reg + 2'd1;
                    state_next = (axis_reg == 2'd2) ? S_REACH0 : S_VMUL;
                end
            end
            S_REACH0:
                state_next = S_REACH1;
            S_REACH1:
            begin
                r_next     = prod;
                state_next = S_REACH2;
            end
            S_REACH2:
            begin
                if ((r_reg + prod) < (wide_t'(1) <<< (2 * CF)))
                    reached_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    ovalid_next = 1'b1;
                    ox_next     = cur_reg[0];
                    oy_next     = cur_reg[1];
                    oz_next     = cur_reg[2];
                    orch_next   = reached_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            axis_reg    <= '0;
            t_reg       <= PARAM_START;
            fwd_reg     <= 1'b1;
            reached_reg <= 1'b1;
            started_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
            speed_reg   <= SPEED_RESET;
            for (int i = 0; i < 4; i++)
                pt_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
            begin
                tgt_reg[i] <= '0;
                cur_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            axis_reg    <= axis_next;
            t_reg       <= t_next;
            fwd_reg     <= fwd_next;
            reached_reg <= reached_next;
            started_reg <= started_next;
            ovalid_reg  <= ovalid_next;
            tgt_reg     <= tgt_next;
            cur_reg     <= cur_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POINT_ZERO:  pt_reg[0] <= cfg_data;
                    REG_POINT_ONE:   pt_reg[1] <= cfg_data;
                    REG_POINT_TWO:   pt_reg[2] <= cfg_data;
                    REG_POINT_THREE: pt_reg[3] <= cfg_data;
                    REG_MOVE_SPEED:  speed_reg <= cfg_data[SPW-1:0];
                    default:         speed_reg <= speed_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg   <= dt_next;
        neg_reg  <= neg_next;
        d_reg    <= d_next;
        w_reg    <= w_next;
        t2_reg   <= t2_next;
        u2_reg   <= u2_next;
        step_reg <= step_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        r_reg    <= r_next;
        len_reg  <= len_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oz_reg   <= oz_next;
        orch_reg <= orch_next;
    end
endmodule
